@@ design/scc_pkg.sv @@
package scc_pkg;

  localparam int unsigned MAX_OBSTACLES = 16;
  localparam int unsigned CoordW = 16;
  localparam int unsigned RadW = 12;
  localparam int unsigned IdW = 8;
  localparam logic [RadW-1:0] ROBOT_RADIUS_RST = 12'd90;

  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_CLEAR = 2'd1;
  localparam logic [1:0] MODE_QUERY = 2'd2;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  typedef enum logic [1:0] {
    OP_INSERT,
    OP_CLEAR,
    OP_QUERY,
    OP_NOP
  } op_e;

  typedef struct packed {
    op_e                       op;
    logic [IdW-1:0]            id;
    logic signed [CoordW-1:0]  ox;
    logic signed [CoordW-1:0]  oy;
    logic [RadW-1:0]           orad;
    logic signed [CoordW-1:0]  sx;
    logic signed [CoordW-1:0]  sy;
    logic signed [CoordW-1:0]  ex;
    logic signed [CoordW-1:0]  ey;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

@@ design/scc_front.sv @@
module scc_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [1:0]         mode_i,
  input  logic [7:0]         obstacle_id_i,
  input  logic signed [15:0] obstacle_x_i,
  input  logic signed [15:0] obstacle_y_i,
  input  logic [11:0]        obstacle_radius_i,
  input  logic signed [15:0] seg_start_x_i,
  input  logic signed [15:0] seg_start_y_i,
  input  logic signed [15:0] seg_end_x_i,
  input  logic signed [15:0] seg_end_y_i,
  input  logic               pop_i,
  output scc_pkg::cmd_t      head_o,
  output scc_pkg::queue_status_t status_o
);

  scc_pkg::cmd_t       slot_q [2];
  scc_pkg::cmd_t       cmd;
  scc_pkg::op_e        op;
  logic                wr_ptr_q, wr_ptr_d;
  logic                rd_ptr_q, rd_ptr_d;
  logic [1:0]          fill_q, fill_d;
  logic                push;

  always_comb begin
    case (mode_i)
      scc_pkg::MODE_INSERT: op = scc_pkg::OP_INSERT;
      scc_pkg::MODE_CLEAR:  op = scc_pkg::OP_CLEAR;
      scc_pkg::MODE_QUERY:  op = scc_pkg::OP_QUERY;
      default:              op = scc_pkg::OP_NOP;
    endcase
  end

  assign cmd = '{op: op, id: obstacle_id_i, ox: obstacle_x_i, oy: obstacle_y_i,
                 orad: obstacle_radius_i, sx: seg_start_x_i, sy: seg_start_y_i,
                 ex: seg_end_x_i, ey: seg_end_y_i};

  assign status_o.full  = (fill_q == 2'd2);
  assign status_o.empty = (fill_q == 2'd0);
  assign push = start_i && !status_o.full;
  assign head_o = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? !rd_ptr_q : rd_ptr_q;
    fill_d = fill_q + 2'(push) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= cmd;
    end
  end

endmodule

@@ design/scc_back.sv @@
module scc_back #(
  parameter int unsigned MaxObstacles = scc_pkg::MAX_OBSTACLES
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  robot_radius_we_i,
  input  logic [11:0]           robot_radius_i,
  input  scc_pkg::cmd_t         head_i,
  input  scc_pkg::queue_status_t qstat_i,
  output logic                  pop_o,
  output logic                  result_valid_o,
  output logic                  collision_free_o,
  output logic                  status_o
);

  localparam int unsigned CntW = $clog2(MaxObstacles + 1);
  localparam int unsigned IdxW = (MaxObstacles > 1) ? $clog2(MaxObstacles) : 1;
  localparam logic [CntW-1:0] MaxCnt = CntW'(MaxObstacles);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SCAN = 3'd1;
  localparam logic [2:0] ST_WRITE = 3'd2;
  localparam logic [2:0] ST_DIFF = 3'd3;
  localparam logic [2:0] ST_LEN = 3'd4;
  localparam logic [2:0] ST_RUN = 3'd5;

  logic [2:0]           state_q, state_d;
  scc_pkg::cmd_t        cmd_q, cmd_d;
  logic [CntW-1:0]      count_q, count_d;
  logic [CntW-1:0]      iss_q, iss_d;
  logic [CntW-1:0]      chk_q, chk_d;
  logic [CntW-1:0]      slot_q, slot_d;
  logic                 rdv_q, rdv_d;
  logic                 issue;
  logic [11:0]          robot_q;
  logic                 res_v_q, res_v_d, free_q, free_d, stat_q, stat_d;
  logic                 hit_q, hit_d;

  logic [51:0]          mem_q [MaxObstacles];
  logic [51:0]          rd_q;
  logic                 mem_we;
  logic [IdxW-1:0]      ra;

  logic signed [16:0]   dx_q, dx_d, dy_q, dy_d;
  logic [33:0]          len2_q;
  logic signed [33:0]   sq_dx, sq_dy;

  logic [7:0]           rd_id;
  logic signed [15:0]   rd_x, rd_y;
  logic [11:0]          rd_r;

  logic                 v2_q, v3_q, v4_q, v5_q;
  logic signed [16:0]   wx_q, wy_q, ex_q, ey_q;
  logic [12:0]          r_q;
  logic signed [33:0]   wxdx_q, wydy_q, wxdy_q, wydx_q, wxwx_q, wywy_q, exex_q, eyey_q;
  logic [25:0]          r2a_q, r2b_q;
  logic signed [34:0]   proj_q, cross_q;
  logic [34:0]          dw_q, de_q;
  logic                 nstart_q, nend_q, dwhit_q, dehit_q, big_q;
  logic [34:0]          cr_mag;
  logic [63:0]          cr2_q;
  logic [59:0]          lim_q;
  logic                 hit5;

  assign {rd_id, rd_x, rd_y, rd_r} = rd_q;
  assign sq_dx = dx_q * dx_q;
  assign sq_dy = dy_q * dy_q;

  always_comb begin
    state_d = state_q;
    cmd_d = cmd_q;
    count_d = count_q;
    iss_d = iss_q;
    chk_d = chk_q;
    slot_d = slot_q;
    rdv_d = 1'b0;
    issue = 1'b0;
    res_v_d = 1'b0;
    free_d = free_q;
    stat_d = stat_q;
    hit_d = hit_q;
    pop_o = 1'b0;
    mem_we = 1'b0;
    dx_d = dx_q;
    dy_d = dy_q;
    case (state_q)
      ST_IDLE: begin
        if (!qstat_i.empty) begin
          pop_o = 1'b1;
          cmd_d = head_i;
          iss_d = '0;
          chk_d = '0;
          case (head_i.op)
            scc_pkg::OP_INSERT: state_d = ST_SCAN;
            scc_pkg::OP_QUERY:  state_d = ST_DIFF;
            scc_pkg::OP_CLEAR: begin
              count_d = '0;
              res_v_d = 1'b1;
              free_d = 1'b1;
              stat_d = 1'b0;
            end
            default: begin
              res_v_d = 1'b1;
              free_d = 1'b1;
              stat_d = 1'b0;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (rdv_q && rd_id == cmd_q.id) begin
          slot_d = chk_q;
          state_d = ST_WRITE;
        end else if (!rdv_q && iss_q >= count_q) begin
          slot_d = count_q;
          state_d = ST_WRITE;
        end else begin
          issue = iss_q < count_q;
          rdv_d = issue;
          chk_d = iss_q;
          iss_d = issue ? iss_q + 1'b1 : iss_q;
        end
      end
      ST_WRITE: begin
        res_v_d = 1'b1;
        free_d = 1'b1;
        state_d = ST_IDLE;
        if (slot_q < MaxCnt) begin
          mem_we = 1'b1;
          stat_d = 1'b0;
          if (slot_q == count_q) count_d = count_q + 1'b1;
        end else begin
          stat_d = 1'b1;
        end
      end
      ST_DIFF: begin
        dx_d = 17'(cmd_q.ex) - 17'(cmd_q.sx);
        dy_d = 17'(cmd_q.ey) - 17'(cmd_q.sy);
        hit_d = 1'b0;
        if ((dx_d == '0 && dy_d == '0) || count_q == '0) begin
          res_v_d = 1'b1;
          free_d = 1'b1;
          stat_d = 1'b0;
          state_d = ST_IDLE;
        end else begin
          state_d = ST_LEN;
        end
      end
      ST_LEN: state_d = ST_RUN;
      ST_RUN: begin
        issue = iss_q < count_q;
        rdv_d = issue;
        iss_d = issue ? iss_q + 1'b1 : iss_q;
        if (v5_q && hit5) hit_d = 1'b1;
        if (!issue && !rdv_q && !v2_q && !v3_q && !v4_q && !v5_q) begin
          res_v_d = 1'b1;
          free_d = !hit_q;
          stat_d = 1'b0;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign ra = mem_we ? slot_q[IdxW-1:0] : iss_q[IdxW-1:0];

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[ra] <= {cmd_q.id, cmd_q.ox, cmd_q.oy, cmd_q.orad};
    end
    if (issue) begin
      rd_q <= mem_q[ra];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      robot_q <= scc_pkg::ROBOT_RADIUS_RST;
      res_v_q <= 1'b0;
      rdv_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (robot_radius_we_i) robot_q <= robot_radius_i;
      res_v_q <= res_v_d;
      rdv_q <= rdv_d;
      v2_q <= rdv_q && state_q == ST_RUN;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  assign cr_mag = cross_q[34] ? 35'(-cross_q) : 35'(cross_q);
  assign hit5 = nstart_q ? dwhit_q : (nend_q ? dehit_q : (!big_q && cr2_q < 64'(lim_q)));

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    iss_q <= iss_d;
    chk_q <= chk_d;
    slot_q <= slot_d;
    free_q <= free_d;
    stat_q <= stat_d;
    hit_q <= hit_d;
    dx_q <= dx_d;
    dy_q <= dy_d;
    if (state_q == ST_LEN) len2_q <= 34'(sq_dx) + 34'(sq_dy);
    wx_q <= 17'(rd_x) - 17'(cmd_q.sx);
    wy_q <= 17'(rd_y) - 17'(cmd_q.sy);
    ex_q <= 17'(rd_x) - 17'(cmd_q.ex);
    ey_q <= 17'(rd_y) - 17'(cmd_q.ey);
    r_q <= 13'(rd_r) + 13'(robot_q);
    wxdx_q <= wx_q * dx_q;
    wydy_q <= wy_q * dy_q;
    wxdy_q <= wx_q * dy_q;
    wydx_q <= wy_q * dx_q;
    wxwx_q <= wx_q * wx_q;
    wywy_q <= wy_q * wy_q;
    exex_q <= ex_q * ex_q;
    eyey_q <= ey_q * ey_q;
    r2a_q <= 26'(r_q * r_q);
    proj_q <= 35'(wxdx_q) + 35'(wydy_q);
    cross_q <= 35'(wxdy_q) - 35'(wydx_q);
    dw_q <= 35'(wxwx_q) + 35'(wywy_q);
    de_q <= 35'(exex_q) + 35'(eyey_q);
    r2b_q <= r2a_q;
    nstart_q <= proj_q <= 35'sd0;
    nend_q <= proj_q >= $signed({1'b0, len2_q});
    dwhit_q <= dw_q < 35'(r2b_q);
    dehit_q <= de_q < 35'(r2b_q);
    big_q <= cr_mag[34:32] != 3'd0;
    cr2_q <= 64'(cr_mag[31:0]) * 64'(cr_mag[31:0]);
    lim_q <= 60'(r2b_q) * 60'(len2_q);
  end

  assign result_valid_o = res_v_q;
  assign collision_free_o = free_q;
  assign status_o = stat_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= MaxCnt) else $error("obstacle count beyond table depth");
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> state_q == ST_IDLE && !qstat_i.empty) else $error("pop outside idle");
  a_drop_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && status_o |-> collision_free_o) else $error("dropped insert not free");
  a_drop_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_v_d && stat_d |-> count_q == MaxCnt) else $error("drop with room left");
  a_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |=> state_q == ST_IDLE) else $error("write not followed by idle");

endmodule

@@ design/segment_circle_collision_checker.sv @@
// Segment versus circle collision checker with an obstacle table.
// Command channel: a word is taken at a rising edge with start_i high and
// busy_o low; mode_i selects insert or update (0), clear (1) or segment
// query (2). A two-word queue parts the command front from the executing
// back end, so busy_o rises only when both queue slots are taken.
// Result channel: every word gives exactly one result, shown for one cycle
// with result_valid_o high; the receiver cannot stall it.
// Clear and unused modes answer straight from idle. An insert scans the
// stored ids, one table entry read per cycle, and then writes its slot; a
// query streams the table memory, one obstacle per cycle, into a multiply
// and compare pipeline. A zero-length segment or an empty table is answered
// from the difference state without streaming the table. The back end
// executes one word at a time, while the queue takes new words until full.
// robot_radius_i is to be written with robot_radius_we_i only while the block
// is idle; the user must keep to this, as the block does not enforce it.
// Reset empties the table and the queue and sets the robot radius to 90 mm.
module segment_circle_collision_checker #(
  parameter int unsigned MaxObstacles = scc_pkg::MAX_OBSTACLES
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [1:0]         mode_i,
  input  logic [7:0]         obstacle_id_i,
  input  logic signed [15:0] obstacle_x_i,
  input  logic signed [15:0] obstacle_y_i,
  input  logic [11:0]        obstacle_radius_i,
  input  logic signed [15:0] seg_start_x_i,
  input  logic signed [15:0] seg_start_y_i,
  input  logic signed [15:0] seg_end_x_i,
  input  logic signed [15:0] seg_end_y_i,
  input  logic               robot_radius_we_i,
  input  logic [11:0]        robot_radius_i,
  output logic               result_valid_o,
  output logic               collision_free_o,
  output logic               status_o
);

  scc_pkg::cmd_t          head;
  scc_pkg::queue_status_t qstat;
  logic                   pop;

  scc_front u_front (
    .clk_i, .rst_ni, .start_i, .mode_i, .obstacle_id_i, .obstacle_x_i,
    .obstacle_y_i, .obstacle_radius_i, .seg_start_x_i, .seg_start_y_i,
    .seg_end_x_i, .seg_end_y_i,
    .pop_i(pop), .head_o(head), .status_o(qstat)
  );

  scc_back #(.MaxObstacles(MaxObstacles)) u_back (
    .clk_i, .rst_ni, .robot_radius_we_i, .robot_radius_i,
    .head_i(head), .qstat_i(qstat), .pop_o(pop),
    .result_valid_o, .collision_free_o, .status_o
  );

  assign busy_o = qstat.full;

endmodule
